/* rtl/tlpm_pkg.sv */
// shared types and constants of the two-level page map engine
// used by tlpm_ctrl, tlpm_dpath and the top level; no dependencies
package tlpm_pkg;

   localparam int PAGE_SHIFT = 12;
   localparam int PAGE_BITS  = 20;
   localparam int SLOT_BITS  = 10;
   localparam int TBL_BITS   = 10;
   localparam int DIR_ENTRIES   = 1 << TBL_BITS;
   localparam int TABLE_ENTRIES = 1 << SLOT_BITS;
   localparam int TOTAL_ENTRIES = 1 << PAGE_BITS;
   localparam int COUNT_BITS = 21;
   localparam int FOUND_BITS = 22;
   localparam int FLAG_BITS  = 12;

   localparam logic [31:0] MIN_ADDR_RESET = 32'h0000_1000;
   localparam logic [31:0] MAX_ADDR_RESET = 32'hFFFF_F000;
   localparam logic [11:0] MAX_FLAGS_RESET = 12'hFFF;

   typedef enum logic [1:0] {
      REG_MIN_ADDR  = 2'd0,
      REG_MAX_ADDR  = 2'd1,
      REG_MAX_FLAGS = 2'd2
   } reg_index_type;

   typedef enum logic [1:0] {
      ACT_MAP     = 2'd0,
      ACT_ALLOC   = 2'd1,
      ACT_RESOLVE = 2'd2
   } action_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_BAD_ADDR = 2'd1,
      ST_BAD_ARG  = 2'd2,
      ST_NO_MEM   = 2'd3
   } status_type;

   typedef enum logic [4:0] {
      S_RST_CLR, S_IDLE, S_DECODE,
      S_MAP_RDP, S_MAP_CHK, S_MAP_CLR, S_MAP_SETP,
      S_FR_TOP, S_FR_P, S_FR_E, S_FR_ED, S_FR_END,
      S_RS_RDP, S_RS_P, S_RS_E,
      S_RESULT
   } state_type;

   typedef enum logic [3:0] {
      DP_NOP, DP_LOAD, DP_RD_PRES, DP_RD_ENT, DP_CLR_ENT, DP_SET_PRES,
      DP_WR_ENT, DP_SCAN_FREE, DP_SCAN_USED, DP_SCAN_ABSENT, DP_START_MAP,
      DP_RESULT, DP_PRES_CLR
   } dp_op_type;

   typedef enum logic [1:0] {
      RK_ZERO, RK_REGION, RK_RESOLVE
   } res_kind_type;

   typedef struct packed {
      dp_op_type    op;
      status_type   res_status;
      res_kind_type res_kind;
   } dp_cmd_type;

   typedef struct packed {
      logic [1:0] act;
      status_type map_chk;
      status_type find_chk;
      logic       pres_bit;
      logic       ent_present;
      logic       clr_last;
      logic       rem_last;
      logic       s_last;
      logic       found_ge;
      logic       past_upper;
      logic       free_done;
      logic       fit_ok;
      logic       out_free;
   } dp_stat_type;

endpackage

/* rtl/tlpm_ctrl.sv */
// sequencer of the page map engine: decodes a request and steps the datapath
// depends on tlpm_pkg
module tlpm_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_accept,
   input  tlpm_pkg::dp_stat_type stat,
   output tlpm_pkg::dp_cmd_type  cmd,
   output logic                 idle
);
   import tlpm_pkg::*;

   state_type    state_ff, state_in;
   status_type   st_ff, st_in;
   res_kind_type kind_ff, kind_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_RST_CLR;
         st_ff    <= ST_OK;
         kind_ff  <= RK_ZERO;
      end else begin
         state_ff <= state_in;
         st_ff    <= st_in;
         kind_ff  <= kind_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      st_in    = st_ff;
      kind_in  = kind_ff;
      case (state_ff)
         S_RST_CLR: begin
            if (stat.clr_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_accept) state_in = S_DECODE;
         end
         S_DECODE: begin
            kind_in = RK_ZERO;
            case (stat.act)
               ACT_MAP: begin
                  if (stat.map_chk != ST_OK) begin
                     st_in    = stat.map_chk;
                     state_in = S_RESULT;
                  end else begin
                     state_in = S_MAP_RDP;
                  end
               end
               ACT_ALLOC: begin
                  if (stat.find_chk != ST_OK) begin
                     st_in    = stat.find_chk;
                     state_in = S_RESULT;
                  end else begin
                     state_in = S_FR_TOP;
                  end
               end
               ACT_RESOLVE: state_in = S_RS_RDP;
               default: begin
                  st_in    = ST_BAD_ARG;
                  state_in = S_RESULT;
               end
            endcase
         end
         S_MAP_RDP: state_in = S_MAP_CHK;
         S_MAP_CHK: begin
            if (!stat.pres_bit) begin
               state_in = S_MAP_CLR;
            end else if (stat.rem_last) begin
               st_in    = ST_OK;
               state_in = S_RESULT;
            end else begin
               state_in = S_MAP_RDP;
            end
         end
         S_MAP_CLR: begin
            if (stat.clr_last) state_in = S_MAP_SETP;
         end
         S_MAP_SETP: state_in = S_MAP_RDP;
         S_FR_TOP: begin
            if (stat.found_ge || stat.past_upper) state_in = S_FR_END;
            else state_in = S_FR_P;
         end
         S_FR_P: begin
            if (stat.pres_bit) state_in = S_FR_E;
            else state_in = S_FR_TOP;
         end
         S_FR_E: state_in = S_FR_ED;
         S_FR_ED: begin
            if (!stat.ent_present && stat.free_done) state_in = S_FR_TOP;
            else if (stat.s_last) state_in = S_FR_TOP;
            else state_in = S_FR_E;
         end
         S_FR_END: begin
            if (!stat.fit_ok) begin
               st_in    = ST_NO_MEM;
               state_in = S_RESULT;
            end else if (stat.map_chk != ST_OK) begin
               st_in    = stat.map_chk;
               state_in = S_RESULT;
            end else begin
               kind_in  = RK_REGION;
               state_in = S_MAP_RDP;
            end
         end
         S_RS_RDP: state_in = S_RS_P;
         S_RS_P: begin
            if (stat.pres_bit) begin
               state_in = S_RS_E;
            end else begin
               st_in    = ST_BAD_ADDR;
               state_in = S_RESULT;
            end
         end
         S_RS_E: begin
            state_in = S_RESULT;
            if (stat.ent_present) begin
               st_in   = ST_OK;
               kind_in = RK_RESOLVE;
            end else begin
               st_in   = ST_BAD_ADDR;
            end
         end
         S_RESULT: begin
            if (stat.out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd.op         = DP_NOP;
      cmd.res_status = st_ff;
      cmd.res_kind   = kind_ff;
      idle           = 1'b0;
      case (state_ff)
         S_RST_CLR: cmd.op = DP_PRES_CLR;
         S_IDLE: begin
            idle = 1'b1;
            if (req_accept) cmd.op = DP_LOAD;
         end
         S_MAP_RDP:  cmd.op = DP_RD_PRES;
         S_MAP_CHK: begin
            if (stat.pres_bit) cmd.op = DP_WR_ENT;
         end
         S_MAP_CLR:  cmd.op = DP_CLR_ENT;
         S_MAP_SETP: cmd.op = DP_SET_PRES;
         S_FR_TOP: begin
            if (!(stat.found_ge || stat.past_upper)) cmd.op = DP_RD_PRES;
         end
         S_FR_P: begin
            if (!stat.pres_bit) cmd.op = DP_SCAN_ABSENT;
         end
         S_FR_E:  cmd.op = DP_RD_ENT;
         S_FR_ED: cmd.op = stat.ent_present ? DP_SCAN_USED : DP_SCAN_FREE;
         S_FR_END: begin
            if (stat.fit_ok && stat.map_chk == ST_OK) cmd.op = DP_START_MAP;
         end
         S_RS_RDP: cmd.op = DP_RD_PRES;
         S_RS_P: begin
            if (stat.pres_bit) cmd.op = DP_RD_ENT;
         end
         S_RESULT: begin
            if (stat.out_free) cmd.op = DP_RESULT;
         end
         default: cmd.op = DP_NOP;
      endcase
   end

endmodule

/* rtl/tlpm_dpath.sv */
// datapath of the page map engine: request registers, walk counters,
// directory and page entry memories, result register; depends on tlpm_pkg
module tlpm_dpath (
   input  logic                 clock,
   input  logic                 reset,
   input  tlpm_pkg::dp_cmd_type  cmd,
   output tlpm_pkg::dp_stat_type stat,
   input  logic [1:0]           in_action,
   input  logic [31:0]          in_phys_addr,
   input  logic [31:0]          in_virt_addr,
   input  logic [20:0]          in_page_count,
   input  logic [31:0]          in_lower_limit,
   input  logic [31:0]          in_upper_limit,
   input  logic [11:0]          in_entry_flags,
   input  logic [31:0]          min_address,
   input  logic [31:0]          max_address,
   input  logic [11:0]          max_flags,
   input  logic                 rsp_ready,
   output logic                 rsp_valid,
   output logic [1:0]           rsp_status,
   output logic [31:0]          rsp_result_addr
);
   import tlpm_pkg::*;

   logic [1:0]            act_ff, act_in;
   logic [31:0]           phys_ff, phys_in, virt_ff, virt_in;
   logic [31:0]           lower_ff, lower_in, upper_ff, upper_in;
   logic [COUNT_BITS-1:0] count_ff, count_in, rem_ff, rem_in;
   logic [FLAG_BITS-1:0]  flags_ff, flags_in;
   logic [PAGE_BITS:0]    pg_ff, pg_in;
   logic [PAGE_BITS-1:0]  pp_ff, pp_in, region_ff, region_in;
   logic [FOUND_BITS-1:0] found_ff, found_in;
   logic [SLOT_BITS-1:0]  clr_ff, clr_in;
   logic                  rv_ff, rv_in;
   logic [1:0]            rs_ff, rs_in;
   logic [31:0]           ra_ff, ra_in;

   logic                  pres_mem [DIR_ENTRIES];
   logic [31:0]           ent_mem [TOTAL_ENTRIES];
   logic                  pres_rd_ff;
   logic [31:0]           ent_rd_ff;

   logic                  pres_we, pres_wd, pres_re, ent_we, ent_re;
   logic [TBL_BITS-1:0]   pres_wa;
   logic [PAGE_BITS-1:0]  ent_wa;
   logic [31:0]           ent_wd;

   logic                  big;
   logic [PAGE_BITS-1:0]  skip;
   logic [31:0]           chk_virt;
   logic [SLOT_BITS:0]    absent_add;
   logic [FOUND_BITS-1:0] found_inc;
   logic [FOUND_BITS-1:0] fit_end;
   logic [31:0]           res_addr;

   function automatic status_type map_check(input logic [31:0] p, input logic [31:0] v,
                                            input logic [20:0] c, input logic [11:0] f,
                                            input logic [11:0] mf);
      status_type r;
      r = ST_OK;
      if (p[11:0] != 12'd0 || v[11:0] != 12'd0) r = ST_BAD_ADDR;
      else if (v == 32'd0 || (p == 32'd0 && f != 12'd0)) r = ST_BAD_ADDR;
      else if (c == 21'd0 || f > mf) r = ST_BAD_ARG;
      return r;
   endfunction

   // a map longer than the address space only needs its last 2^20 pages
   assign big  = in_page_count[COUNT_BITS-1] && (in_page_count[PAGE_BITS-1:0] != '0);
   assign skip = (big && in_action == ACT_MAP) ? in_page_count[PAGE_BITS-1:0] : '0;

   assign chk_virt   = (act_ff == ACT_ALLOC) ? {region_ff, 12'd0} : virt_ff;
   assign absent_add = (SLOT_BITS+1)'(TABLE_ENTRIES) - {1'b0, pg_ff[SLOT_BITS-1:0]};
   assign found_inc  = found_ff + FOUND_BITS'(1);
   assign fit_end    = FOUND_BITS'(region_ff) + FOUND_BITS'(count_ff);

   always_comb begin
      stat.act         = act_ff;
      stat.map_chk     = map_check(phys_ff, chk_virt, count_ff, flags_ff, max_flags);
      if (lower_ff[11:0] != 12'd0 || upper_ff[11:0] != 12'd0)
         stat.find_chk = ST_BAD_ADDR;
      else if (count_ff == '0 || lower_ff < min_address || upper_ff > max_address)
         stat.find_chk = ST_BAD_ARG;
      else
         stat.find_chk = ST_OK;
      stat.pres_bit    = pres_rd_ff;
      stat.ent_present = ent_rd_ff[0];
      stat.clr_last    = (clr_ff == '1);
      stat.rem_last    = (rem_ff == COUNT_BITS'(1));
      stat.s_last      = (pg_ff[SLOT_BITS-1:0] == '1);
      stat.found_ge    = (found_ff >= FOUND_BITS'(count_ff));
      stat.past_upper  = ({pg_ff[PAGE_BITS:SLOT_BITS], 22'd0} >= {1'b0, upper_ff});
      stat.free_done   = (found_inc >= FOUND_BITS'(count_ff));
      stat.fit_ok      = stat.found_ge && ({fit_end, 12'd0} <= {2'b00, upper_ff});
      stat.out_free    = !rv_ff || rsp_ready;
   end

   always_comb begin
      case (cmd.res_kind)
         RK_REGION:  res_addr = {region_ff, 12'd0};
         RK_RESOLVE: res_addr = {ent_rd_ff[31:12], virt_ff[11:0]};
         default:    res_addr = 32'd0;
      endcase
   end

   always_comb begin
      act_in    = act_ff;
      phys_in   = phys_ff;
      virt_in   = virt_ff;
      lower_in  = lower_ff;
      upper_in  = upper_ff;
      count_in  = count_ff;
      flags_in  = flags_ff;
      pg_in     = pg_ff;
      pp_in     = pp_ff;
      rem_in    = rem_ff;
      region_in = region_ff;
      found_in  = found_ff;
      clr_in    = clr_ff;
      rs_in     = rs_ff;
      ra_in     = ra_ff;
      rv_in     = rsp_ready ? 1'b0 : rv_ff;
      pres_we = 1'b0; pres_wd = 1'b0; pres_wa = pg_ff[PAGE_BITS-1:SLOT_BITS];
      pres_re = 1'b0;
      ent_we  = 1'b0; ent_re  = 1'b0;
      ent_wa  = pg_ff[PAGE_BITS-1:0];
      ent_wd  = {pp_ff, flags_ff};
      case (cmd.op)
         DP_LOAD: begin
            act_in   = in_action;
            phys_in  = in_phys_addr;
            virt_in  = in_virt_addr;
            lower_in = in_lower_limit;
            upper_in = in_upper_limit;
            count_in = in_page_count;
            flags_in = in_entry_flags;
            found_in = '0;
            pp_in    = in_phys_addr[31:12] + skip;
            rem_in   = big ? COUNT_BITS'(TOTAL_ENTRIES) : in_page_count;
            if (in_action == ACT_ALLOC)
               pg_in = {1'b0, in_lower_limit[31:12]};
            else
               pg_in = {1'b0, in_virt_addr[31:12] + skip};
         end
         DP_RD_PRES: pres_re = 1'b1;
         DP_RD_ENT:  ent_re  = 1'b1;
         DP_CLR_ENT: begin
            ent_we = 1'b1;
            ent_wa = {pg_ff[PAGE_BITS-1:SLOT_BITS], clr_ff};
            ent_wd = 32'd0;
            clr_in = clr_ff + SLOT_BITS'(1);
         end
         DP_SET_PRES: begin
            pres_we = 1'b1;
            pres_wd = 1'b1;
         end
         DP_WR_ENT: begin
            ent_we = 1'b1;
            pg_in  = {1'b0, pg_ff[PAGE_BITS-1:0] + PAGE_BITS'(1)};
            pp_in  = pp_ff + PAGE_BITS'(1);
            rem_in = rem_ff - COUNT_BITS'(1);
         end
         DP_SCAN_FREE: begin
            if (found_ff == '0) region_in = pg_ff[PAGE_BITS-1:0];
            found_in = found_inc;
            if (stat.free_done)
               pg_in = {pg_ff[PAGE_BITS:SLOT_BITS] + 11'd1, {SLOT_BITS{1'b0}}};
            else
               pg_in = pg_ff + (PAGE_BITS+1)'(1);
         end
         DP_SCAN_USED: begin
            found_in = '0;
            pg_in    = pg_ff + (PAGE_BITS+1)'(1);
         end
         DP_SCAN_ABSENT: begin
            if (found_ff == '0) region_in = pg_ff[PAGE_BITS-1:0];
            found_in = found_ff + FOUND_BITS'(absent_add);
            pg_in    = {pg_ff[PAGE_BITS:SLOT_BITS] + 11'd1, {SLOT_BITS{1'b0}}};
         end
         DP_START_MAP: begin
            pg_in  = {1'b0, region_ff};
            pp_in  = phys_ff[31:12];
            rem_in = count_ff;
         end
         DP_RESULT: begin
            rv_in = 1'b1;
            rs_in = cmd.res_status;
            ra_in = (cmd.res_status == ST_OK) ? res_addr : 32'd0;
         end
         DP_PRES_CLR: begin
            pres_we = 1'b1;
            pres_wa = clr_ff;
            clr_in  = clr_ff + SLOT_BITS'(1);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
         rv_ff  <= 1'b0;
      end else begin
         clr_ff <= clr_in;
         rv_ff  <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff    <= act_in;
      phys_ff   <= phys_in;
      virt_ff   <= virt_in;
      lower_ff  <= lower_in;
      upper_ff  <= upper_in;
      count_ff  <= count_in;
      flags_ff  <= flags_in;
      pg_ff     <= pg_in;
      pp_ff     <= pp_in;
      rem_ff    <= rem_in;
      region_ff <= region_in;
      found_ff  <= found_in;
      rs_ff     <= rs_in;
      ra_ff     <= ra_in;
   end

   // directory present bits
   always_ff @(posedge clock) begin
      if (pres_we) pres_mem[pres_wa] <= pres_wd;
      if (pres_re) pres_rd_ff <= pres_mem[pg_ff[PAGE_BITS-1:SLOT_BITS]];
   end

   // page entries, cleared a table at a time when the table is created
   always_ff @(posedge clock) begin
      if (ent_we) ent_mem[ent_wa] <= ent_wd;
      if (ent_re) ent_rd_ff <= ent_mem[pg_ff[PAGE_BITS-1:0]];
   end

   assign rsp_valid       = rv_ff;
   assign rsp_status      = rs_ff;
   assign rsp_result_addr = ra_ff;

endmodule

/* rtl/two_level_page_map_engine_unit.sv */
// Two-level page map engine: keeps a directory of 1024 table-present bits and
// 2^20 page entries (frame in bits 31..12, flags in 11..0, bit 0 present) and
// serves map range, first-fit allocate and resolve requests, one at a time.
// After reset the directory is swept clear before the first request is
// taken. Resolve reads the directory bit and then the page entry. Mapping
// writes one entry per page, and whenever a table is created its 1024
// entries are first zeroed through the single entry memory port. An
// allocation search inspects entries in present tables and passes over
// absent tables whole, then maps as above. The result sits in an output
// register, so the next request is taken while it waits to be read.
// Depends on tlpm_pkg, tlpm_ctrl and tlpm_dpath.
module two_level_page_map_engine_unit (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // action[1:0], phys_addr[33:2], virt_addr[65:34], page_count[86:66],
   // lower_limit[118:87], upper_limit[150:119], entry_flags[162:151], zero pad
   input  logic [167:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // status[1:0], result_addr[33:2], zero pad
   output logic [39:0]  rsp_tdata,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [3:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);
   import tlpm_pkg::*;

   logic [31:0] min_addr_ff, max_addr_ff;
   logic [11:0] max_flags_ff;
   logic        cfg_wr;
   logic        idle, req_accept;
   dp_cmd_type  cmd;
   dp_stat_type stat;
   logic [1:0]  status;
   logic [31:0] result_addr;

   assign csr_pready = 1'b1;
   assign cfg_wr     = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_addr_ff  <= MIN_ADDR_RESET;
         max_addr_ff  <= MAX_ADDR_RESET;
         max_flags_ff <= MAX_FLAGS_RESET;
      end else if (cfg_wr) begin
         case (csr_paddr[3:2])
            REG_MIN_ADDR:  min_addr_ff  <= csr_pwdata;
            REG_MAX_ADDR:  max_addr_ff  <= csr_pwdata;
            REG_MAX_FLAGS: max_flags_ff <= csr_pwdata[11:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         REG_MIN_ADDR:  csr_prdata = min_addr_ff;
         REG_MAX_ADDR:  csr_prdata = max_addr_ff;
         REG_MAX_FLAGS: csr_prdata = {20'd0, max_flags_ff};
         default:       csr_prdata = 32'd0;
      endcase
   end

   assign req_tready = idle;
   assign req_accept = req_tvalid && idle;

   tlpm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_accept (req_accept),
      .stat       (stat),
      .cmd        (cmd),
      .idle       (idle)
   );

   tlpm_dpath u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .in_action       (req_tdata[1:0]),
      .in_phys_addr    (req_tdata[33:2]),
      .in_virt_addr    (req_tdata[65:34]),
      .in_page_count   (req_tdata[86:66]),
      .in_lower_limit  (req_tdata[118:87]),
      .in_upper_limit  (req_tdata[150:119]),
      .in_entry_flags  (req_tdata[162:151]),
      .min_address     (min_addr_ff),
      .max_address     (max_addr_ff),
      .max_flags       (max_flags_ff),
      .rsp_ready       (rsp_tready),
      .rsp_valid       (rsp_tvalid),
      .rsp_status      (status),
      .rsp_result_addr (result_addr)
   );

   assign rsp_tdata = {6'd0, result_addr, status};

endmodule
